// ----- design/tfn_pkg.sv -----
package tfn_pkg;

    // field widths
    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;
    localparam int COORD_WIDTH   = 16;
    localparam int OUT_FRAC_BITS = 14;

    // datapath widths
    localparam int EDGE_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W - 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int LEN_W   = SQ_W + 2;
    localparam int REM_W   = LEN_W + 1;
    localparam int QBITS   = 2 * OUT_FRAC_BITS + 1;
    localparam int OP_W    = 2 * OUT_FRAC_BITS + 2;
    localparam int ROOT_STEPS = OUT_FRAC_BITS + 1;
    localparam int RT_W    = OUT_FRAC_BITS + 1;

    // full unit length in the output format
    localparam int UNIT = 1 << OUT_FRAC_BITS;

    // pipeline depth: cross 3, length 2, divide, root, output 1
    localparam int LATENCY = 3 + 2 + QBITS + ROOT_STEPS + 1;

    // control that travels beside the data
    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] neg;
    } t_ctl;

    // low COORD_WIDTH bits, sign extended to edge width
    function automatic logic signed [EDGE_W-1:0] coord_ext(input logic [IN_W-1:0] raw);
        logic signed [COORD_WIDTH-1:0] c;
        c = signed'(raw[COORD_WIDTH-1:0]);
        return EDGE_W'(c);
    endfunction

endpackage

// ----- design/triangle_face_normal.sv -----
// Triangle face normal, fully pipelined.
// Input: raise start for one cycle with the nine vertex coordinates (signed
// Q8.8) on i_ax .. i_cz; the transfer happens at that clock edge. busy is
// always low, so a new triangle may be presented in every cycle.
// Output: o_valid pulses for one cycle with o_norm_x/y/z (signed Q2.14 unit
// normal, truncated toward zero) and o_degenerate. A triangle whose cross
// product is zero gives a zero vector with o_degenerate set.
// Pipeline: the cross product, the squared length, the restoring divide
// (one quotient bit per stage), the integer square root (one root bit per
// stage) and the output register, in that order.
// Throughput: one triangle per cycle; results leave in input order.
// Reset (synchronous, active low) clears every valid bit in the pipe, so
// items in flight are dropped and no strobe follows until new input.
// The receiver cannot stall; results are presented once and not held.
module triangle_face_normal (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [tfn_pkg::IN_W-1:0] i_ax,
    input  logic [tfn_pkg::IN_W-1:0] i_ay,
    input  logic [tfn_pkg::IN_W-1:0] i_az,
    input  logic [tfn_pkg::IN_W-1:0] i_bx,
    input  logic [tfn_pkg::IN_W-1:0] i_by_coord,
    input  logic [tfn_pkg::IN_W-1:0] i_bz,
    input  logic [tfn_pkg::IN_W-1:0] i_cx,
    input  logic [tfn_pkg::IN_W-1:0] i_cy,
    input  logic [tfn_pkg::IN_W-1:0] i_cz,
    output logic                     o_valid,
    output logic [tfn_pkg::OUT_W-1:0] o_norm_x,
    output logic [tfn_pkg::OUT_W-1:0] o_norm_y,
    output logic [tfn_pkg::OUT_W-1:0] o_norm_z,
    output logic                     o_degenerate
);
    tfn_pkg::t_ctl                  w_ctl_cr, w_ctl_len, w_ctl_div, w_ctl_rt;
    logic [2:0][tfn_pkg::MAG_W-1:0] w_mag;
    logic [2:0][tfn_pkg::SQ_W-1:0]  w_sq;
    logic [tfn_pkg::LEN_W-1:0]      w_len;
    logic [2:0][tfn_pkg::QBITS-1:0] w_quo;
    logic [2:0][tfn_pkg::RT_W-1:0]  w_root;
    logic [2:0][tfn_pkg::OUT_W-1:0] n_norm;
    logic [2:0][tfn_pkg::OUT_W-1:0] r_norm;
    logic                           r_valid;
    logic                           r_degen;

    // the pipe never refuses a transfer
    assign busy = 1'b0;

    tfn_cross u_cross (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start),
        .i_ax       (i_ax),
        .i_ay       (i_ay),
        .i_az       (i_az),
        .i_bx       (i_bx),
        .i_by_coord (i_by_coord),
        .i_bz       (i_bz),
        .i_cx       (i_cx),
        .i_cy       (i_cy),
        .i_cz       (i_cz),
        .o_ctl      (w_ctl_cr),
        .o_mag      (w_mag)
    );

    tfn_length u_length (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_cr),
        .i_mag   (w_mag),
        .o_ctl   (w_ctl_len),
        .o_sq    (w_sq),
        .o_len   (w_len)
    );

    // component square over squared length, scaled by 2^(2*frac)
    tfn_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_len),
        .i_sq    (w_sq),
        .i_len   (w_len),
        .o_ctl   (w_ctl_div),
        .o_quo   (w_quo)
    );

    tfn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_div),
        .i_quo   (w_quo),
        .o_ctl   (w_ctl_rt),
        .o_root  (w_root)
    );

    // apply sign, force zero for a degenerate triangle
    always_comb begin
        logic [tfn_pkg::OUT_W-1:0] m;
        for (int l = 0; l < 3; l++) begin
            m = tfn_pkg::OUT_W'(w_root[l]);
            if (w_ctl_rt.degen) begin
                n_norm[l] = '0;
            end else if (w_ctl_rt.neg[l]) begin
                n_norm[l] = -m;
            end else begin
                n_norm[l] = m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctl_rt.valid;
        end
        r_norm  <= n_norm;
        r_degen <= w_ctl_rt.degen;
    end

    assign o_valid      = r_valid;
    assign o_norm_x     = r_norm[0];
    assign o_norm_y     = r_norm[1];
    assign o_norm_z     = r_norm[2];
    assign o_degenerate = r_degen;

    // degenerate result carries a zero vector
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_norm_x == '0 && o_norm_y == '0 && o_norm_z == '0)
        else $error("degenerate result with nonzero normal");

    // a real normal always has some nonzero component
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> o_norm_x != '0 || o_norm_y != '0 || o_norm_z != '0)
        else $error("non-degenerate result with zero normal");

    // components stay within unit range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> int'($signed(o_norm_x)) <= tfn_pkg::UNIT
                 && int'($signed(o_norm_x)) >= -tfn_pkg::UNIT
                 && int'($signed(o_norm_y)) <= tfn_pkg::UNIT
                 && int'($signed(o_norm_y)) >= -tfn_pkg::UNIT
                 && int'($signed(o_norm_z)) <= tfn_pkg::UNIT
                 && int'($signed(o_norm_z)) >= -tfn_pkg::UNIT)
        else $error("normal component out of unit range");
endmodule

// ----- design/tfn_cross.sv -----
module tfn_cross (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [tfn_pkg::IN_W-1:0]      i_ax,
    input  logic [tfn_pkg::IN_W-1:0]      i_ay,
    input  logic [tfn_pkg::IN_W-1:0]      i_az,
    input  logic [tfn_pkg::IN_W-1:0]      i_bx,
    input  logic [tfn_pkg::IN_W-1:0]      i_by_coord,
    input  logic [tfn_pkg::IN_W-1:0]      i_bz,
    input  logic [tfn_pkg::IN_W-1:0]      i_cx,
    input  logic [tfn_pkg::IN_W-1:0]      i_cy,
    input  logic [tfn_pkg::IN_W-1:0]      i_cz,
    output tfn_pkg::t_ctl                 o_ctl,
    output logic [2:0][tfn_pkg::MAG_W-1:0] o_mag
);
    // edge vectors
    logic signed [tfn_pkg::EDGE_W-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic                              r_v0;
    // cross product partial products
    logic signed [tfn_pkg::PROD_W-1:0] r_p [6];
    logic                              r_v1;
    // components
    logic signed [tfn_pkg::CROSS_W-1:0] n_n [3];
    logic [2:0][tfn_pkg::MAG_W-1:0]     r_mag;
    tfn_pkg::t_ctl                      r_ctl;
    tfn_pkg::t_ctl                      n_ctl;
    logic [2:0][tfn_pkg::MAG_W-1:0]     n_mag;

    // stage 1: edges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
        end
        r_e1x <= tfn_pkg::coord_ext(i_bx) - tfn_pkg::coord_ext(i_ax);
        r_e1y <= tfn_pkg::coord_ext(i_by_coord) - tfn_pkg::coord_ext(i_ay);
        r_e1z <= tfn_pkg::coord_ext(i_bz) - tfn_pkg::coord_ext(i_az);
        r_e2x <= tfn_pkg::coord_ext(i_cx) - tfn_pkg::coord_ext(i_ax);
        r_e2y <= tfn_pkg::coord_ext(i_cy) - tfn_pkg::coord_ext(i_ay);
        r_e2z <= tfn_pkg::coord_ext(i_cz) - tfn_pkg::coord_ext(i_az);
    end

    // stage 2: six products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
        r_p[0] <= r_e1y * r_e2z;
        r_p[1] <= r_e1z * r_e2y;
        r_p[2] <= r_e1z * r_e2x;
        r_p[3] <= r_e1x * r_e2z;
        r_p[4] <= r_e1x * r_e2y;
        r_p[5] <= r_e1y * r_e2x;
    end

    // stage 3: components, signs and magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_n[i] = tfn_pkg::CROSS_W'(r_p[2*i]) - tfn_pkg::CROSS_W'(r_p[2*i+1]);
            n_mag[i] = n_n[i][tfn_pkg::CROSS_W-1] ?
                       tfn_pkg::MAG_W'(-n_n[i]) : tfn_pkg::MAG_W'(n_n[i]);
            n_ctl.neg[i] = n_n[i][tfn_pkg::CROSS_W-1];
        end
        n_ctl.valid = r_v1;
        n_ctl.degen = (n_n[0] == '0) && (n_n[1] == '0) && (n_n[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_mag <= n_mag;
    end

    assign o_ctl = r_ctl;
    assign o_mag = r_mag;
endmodule

// ----- design/tfn_length.sv -----
module tfn_length (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tfn_pkg::t_ctl                  i_ctl,
    input  logic [2:0][tfn_pkg::MAG_W-1:0] i_mag,
    output tfn_pkg::t_ctl                  o_ctl,
    output logic [2:0][tfn_pkg::SQ_W-1:0]  o_sq,
    output logic [tfn_pkg::LEN_W-1:0]      o_len
);
    logic [2:0][tfn_pkg::SQ_W-1:0] r_sq0;
    logic [2:0][tfn_pkg::SQ_W-1:0] r_sq1;
    logic [tfn_pkg::LEN_W-1:0]     r_len;
    tfn_pkg::t_ctl                 r_ctl0;
    tfn_pkg::t_ctl                 r_ctl1;

    // squares of the component magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else begin
            r_ctl0 <= i_ctl;
        end
        for (int i = 0; i < 3; i++) begin
            r_sq0[i] <= tfn_pkg::SQ_W'(i_mag[i]) * tfn_pkg::SQ_W'(i_mag[i]);
        end
    end

    // squared length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= r_ctl0;
        end
        r_len <= tfn_pkg::LEN_W'(r_sq0[0]) + tfn_pkg::LEN_W'(r_sq0[1])
               + tfn_pkg::LEN_W'(r_sq0[2]);
        r_sq1 <= r_sq0;
    end

    assign o_ctl = r_ctl1;
    assign o_sq  = r_sq1;
    assign o_len = r_len;
endmodule

// ----- design/tfn_divider.sv -----
module tfn_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tfn_pkg::t_ctl                  i_ctl,
    input  logic [2:0][tfn_pkg::SQ_W-1:0]  i_sq,
    input  logic [tfn_pkg::LEN_W-1:0]      i_len,
    output tfn_pkg::t_ctl                  o_ctl,
    output logic [2:0][tfn_pkg::QBITS-1:0] o_quo
);
    // one quotient bit per stage, three lanes sharing the divisor
    logic [2:0][tfn_pkg::REM_W-1:0] r_rem [tfn_pkg::QBITS];
    logic [2:0][tfn_pkg::QBITS-1:0] r_quo [tfn_pkg::QBITS];
    logic [tfn_pkg::LEN_W-1:0]      r_den [tfn_pkg::QBITS];
    tfn_pkg::t_ctl                  r_ctl [tfn_pkg::QBITS];

    for (genvar s = 0; s < tfn_pkg::QBITS; s++) begin : g_st
        logic [2:0][tfn_pkg::REM_W-1:0] w_rem;
        logic [2:0][tfn_pkg::QBITS-1:0] w_quo;
        logic [tfn_pkg::LEN_W-1:0]      w_den;
        tfn_pkg::t_ctl                  w_ctl;
        logic [2:0][tfn_pkg::REM_W-1:0] n_rem;
        logic [2:0][tfn_pkg::QBITS-1:0] n_quo;

        // stage input
        if (s == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    w_rem[l] = tfn_pkg::REM_W'(i_sq[l]);
                end
            end
            assign w_quo = '0;
            assign w_den = i_len;
            assign w_ctl = i_ctl;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_quo = r_quo[s-1];
            assign w_den = r_den[s-1];
            assign w_ctl = r_ctl[s-1];
        end

        // compare, subtract, shift
        always_comb begin
            logic [tfn_pkg::REM_W-1:0] diff;
            logic                      ge;
            for (int l = 0; l < 3; l++) begin
                ge   = w_rem[l] >= tfn_pkg::REM_W'(w_den);
                diff = w_rem[l] - tfn_pkg::REM_W'(w_den);
                n_rem[l] = ge ? {diff[tfn_pkg::REM_W-2:0], 1'b0}
                              : {w_rem[l][tfn_pkg::REM_W-2:0], 1'b0};
                n_quo[l] = {w_quo[l][tfn_pkg::QBITS-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s] <= '0;
            end else begin
                r_ctl[s] <= w_ctl;
            end
            r_rem[s] <= n_rem;
            r_quo[s] <= n_quo;
            r_den[s] <= w_den;
        end
    end

    assign o_ctl = r_ctl[tfn_pkg::QBITS-1];
    assign o_quo = r_quo[tfn_pkg::QBITS-1];
endmodule

// ----- design/tfn_isqrt.sv -----
module tfn_isqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tfn_pkg::t_ctl                  i_ctl,
    input  logic [2:0][tfn_pkg::QBITS-1:0] i_quo,
    output tfn_pkg::t_ctl                  o_ctl,
    output logic [2:0][tfn_pkg::RT_W-1:0]  o_root
);
    // one root bit per stage, remainder and partial root per lane
    logic [2:0][tfn_pkg::OP_W-1:0] r_op  [tfn_pkg::ROOT_STEPS];
    logic [2:0][tfn_pkg::OP_W-1:0] r_res [tfn_pkg::ROOT_STEPS];
    tfn_pkg::t_ctl                 r_ctl [tfn_pkg::ROOT_STEPS];

    for (genvar s = 0; s < tfn_pkg::ROOT_STEPS; s++) begin : g_st
        localparam logic [tfn_pkg::OP_W-1:0] BIT_S =
            tfn_pkg::OP_W'(1) << (2 * (tfn_pkg::ROOT_STEPS - 1 - s));
        logic [2:0][tfn_pkg::OP_W-1:0] w_op;
        logic [2:0][tfn_pkg::OP_W-1:0] w_res;
        tfn_pkg::t_ctl                 w_ctl;
        logic [2:0][tfn_pkg::OP_W-1:0] n_op;
        logic [2:0][tfn_pkg::OP_W-1:0] n_res;

        // stage input
        if (s == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    w_op[l] = tfn_pkg::OP_W'(i_quo[l]);
                end
            end
            assign w_res = '0;
            assign w_ctl = i_ctl;
        end else begin : g_next
            assign w_op  = r_op[s-1];
            assign w_res = r_res[s-1];
            assign w_ctl = r_ctl[s-1];
        end

        // trial subtract of root plus current bit
        always_comb begin
            logic [tfn_pkg::OP_W-1:0] trial;
            logic                     ge;
            for (int l = 0; l < 3; l++) begin
                trial    = w_res[l] + BIT_S;
                ge       = w_op[l] >= trial;
                n_op[l]  = ge ? w_op[l] - trial : w_op[l];
                n_res[l] = ge ? (w_res[l] >> 1) + BIT_S : w_res[l] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s] <= '0;
            end else begin
                r_ctl[s] <= w_ctl;
            end
            r_op[s]  <= n_op;
            r_res[s] <= n_res;
        end
    end

    assign o_ctl = r_ctl[tfn_pkg::ROOT_STEPS-1];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_root[l] = r_res[tfn_pkg::ROOT_STEPS-1][l][tfn_pkg::RT_W-1:0];
        end
    end
endmodule

// ----- sim/triangle_face_normal_tb.sv -----
module triangle_face_normal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 700;
    localparam int TAIL_CYCLES = tfn_pkg::LATENCY + 20;

    // one face normal as it appears on the result ports
    typedef struct packed {
        logic [tfn_pkg::OUT_W-1:0] x;
        logic [tfn_pkg::OUT_W-1:0] y;
        logic [tfn_pkg::OUT_W-1:0] z;
        logic                      degen;
    } t_normal;

    // nine coordinates in port order ax ay az bx by bz cx cy cz
    typedef logic [0:8][tfn_pkg::IN_W-1:0] t_tri;

    // directed stimulus row, result typed in where known
    typedef struct packed {
        t_tri    tri_in;
        logic    known;
        t_normal res;
    } t_row;

    localparam logic [15:0] P = 16'h7FFF;
    localparam logic [15:0] M = 16'h8000;
    localparam logic [15:0] ONE = 16'h0100;
    localparam logic [15:0] U_POS = 16'h4000;
    localparam logic [15:0] U_NEG = 16'hC000;

    localparam int N_ROWS = 12;
    t_row dir_rows [N_ROWS] = '{
        // all vertices at the origin
        '{'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
          1'b1, '{16'h0, 16'h0, 16'h0, 1'b1}},
        // unit triangle in the xy plane, normal +z
        '{'{16'h0, 16'h0, 16'h0, ONE, 16'h0, 16'h0, 16'h0, ONE, 16'h0},
          1'b1, '{16'h0, 16'h0, U_POS, 1'b0}},
        // same triangle, opposite winding
        '{'{16'h0, 16'h0, 16'h0, 16'h0, ONE, 16'h0, ONE, 16'h0, 16'h0},
          1'b1, '{16'h0, 16'h0, U_NEG, 1'b0}},
        // yz plane, normal +x
        '{'{16'h0, 16'h0, 16'h0, 16'h0, ONE, 16'h0, 16'h0, 16'h0, ONE},
          1'b1, '{U_POS, 16'h0, 16'h0, 1'b0}},
        // zx plane, normal +y
        '{'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ONE, ONE, 16'h0, 16'h0},
          1'b1, '{16'h0, U_POS, 16'h0, 1'b0}},
        // largest edges, axis aligned normal
        '{'{M, M, M, P, M, M, M, P, M},
          1'b1, '{16'h0, 16'h0, U_POS, 1'b0}},
        '{'{P, P, P, M, P, P, P, P, M},
          1'b1, '{16'h0, U_NEG, 16'h0, 1'b0}},
        // collinear across the full range
        '{'{M, M, M, P, P, P, 16'hFFFF, 16'hFFFF, 16'hFFFF},
          1'b1, '{16'h0, 16'h0, 16'h0, 1'b1}},
        // coincident vertices at the extremes
        '{'{P, M, P, P, M, P, 16'h1234, 16'h0, 16'hFFFF},
          1'b1, '{16'h0, 16'h0, 16'h0, 1'b1}},
        // smallest nonzero cross product
        '{'{16'h0, 16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'h1, 16'h0},
          1'b1, '{16'h0, 16'h0, U_POS, 1'b0}},
        // oblique, left to the predictor
        '{'{M, P, M, P, M, P, P, P, M}, 1'b0, '0},
        '{'{16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8001,
            16'h00FF, 16'hFF00, 16'h3C3C}, 1'b0, '0}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [tfn_pkg::IN_W-1:0]  i_ax, i_ay, i_az, i_bx, i_by_coord, i_bz, i_cx, i_cy, i_cz;
    logic                      o_valid;
    logic [tfn_pkg::OUT_W-1:0] o_norm_x, o_norm_y, o_norm_z;
    logic                      o_degenerate;

    t_normal pending_normals [$];
    int      n_errors = 0;

    triangle_face_normal i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_ax         (i_ax),
        .i_ay         (i_ay),
        .i_az         (i_az),
        .i_bx         (i_bx),
        .i_by_coord   (i_by_coord),
        .i_bz         (i_bz),
        .i_cx         (i_cx),
        .i_cy         (i_cy),
        .i_cz         (i_cz),
        .o_valid      (o_valid),
        .o_norm_x     (o_norm_x),
        .o_norm_y     (o_norm_y),
        .o_norm_z     (o_norm_z),
        .o_degenerate (o_degenerate)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #400us;
        $display("simulation failed");
        $finish;
    end

    // largest q with q^2 * len2 <= mag^2 * 2^(2*frac)
    function automatic logic [tfn_pkg::OUT_W-1:0] unit_component(input logic [127:0] mag_n,
                                                                input logic [127:0] len2);
        logic [127:0] target;
        logic [127:0] q;
        logic [127:0] c;
        target = (mag_n * mag_n) << (2 * tfn_pkg::OUT_FRAC_BITS);
        q = '0;
        for (int b = tfn_pkg::OUT_FRAC_BITS; b >= 0; b--) begin
            c = q | (128'd1 << b);
            if (c * c * len2 <= target)
                q = c;
        end
        return q[tfn_pkg::OUT_W-1:0];
    endfunction

    // exact cross product scaled to unit length
    function automatic t_normal face_normal(input t_tri t);
        longint       pt [9];
        longint       e1 [3];
        longint       e2 [3];
        longint       n [3];
        logic [127:0] mag_n [3];
        logic [127:0] len2;
        t_normal      r;
        logic [tfn_pkg::OUT_W-1:0] q;
        for (int i = 0; i < 9; i++)
            pt[i] = longint'(signed'(t[i][tfn_pkg::COORD_WIDTH-1:0]));
        for (int i = 0; i < 3; i++) begin
            e1[i] = pt[3 + i] - pt[i];
            e2[i] = pt[6 + i] - pt[i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        r = '0;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            r.degen = 1'b1;
            return r;
        end
        len2 = '0;
        for (int i = 0; i < 3; i++) begin
            mag_n[i] = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
            len2 += mag_n[i] * mag_n[i];
        end
        for (int i = 0; i < 3; i++) begin
            q = unit_component(mag_n[i], len2);
            if (n[i] < 0)
                q = -q;
            case (i)
                0: r.x = q;
                1: r.y = q;
                default: r.z = q;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [tfn_pkg::OUT_W-1:0] got,
                                   input logic [tfn_pkg::OUT_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        n_errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_normal want;
        if (i_rst_n && o_valid) begin
            if (pending_normals.size() == 0) begin
                // result with no transfer pending
                report_mismatch("valid", 16'h1, 16'h0);
            end else begin
                want = pending_normals.pop_front();
                if (o_norm_x !== want.x)
                    report_mismatch("norm_x", o_norm_x, want.x);
                if (o_norm_y !== want.y)
                    report_mismatch("norm_y", o_norm_y, want.y);
                if (o_norm_z !== want.z)
                    report_mismatch("norm_z", o_norm_z, want.z);
                if (o_degenerate !== want.degen)
                    report_mismatch("degenerate", 16'(o_degenerate), 16'(want.degen));
            end
        end
    end

    // present one triangle and hold it until the transfer
    task automatic send_triangle(input t_tri t, input logic known, input t_normal res);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        {i_ax, i_ay, i_az, i_bx, i_by_coord, i_bz, i_cx, i_cy, i_cz} <= t;
        do
            @(posedge i_clk);
        while (busy);
        pending_normals.push_back(known ? res : face_normal(t));
    endtask

    function automatic logic [15:0] small_coord();
        return 16'($signed($urandom_range(0, 4000)) - 2000);
    endfunction

    function automatic t_tri random_triangle();
        t_tri t;
        int   kind;
        int   k;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            t[i] = (kind < 5) ? 16'($urandom) : small_coord();
        // collinear: C on the line through A and B
        if (kind == 8) begin
            k = $signed($urandom_range(0, 6)) - 3;
            for (int i = 0; i < 3; i++)
                t[6 + i] = 16'(int'($signed(t[i])) +
                               k * (int'($signed(t[3 + i])) - int'($signed(t[i]))));
        end
        // two vertices coincide
        if (kind == 9)
            for (int i = 0; i < 3; i++)
                t[3 + i] = t[i];
        return t;
    endfunction

    // stimulus
    initial begin
        start = 1'b0;
        {i_ax, i_ay, i_az, i_bx, i_by_coord, i_bz, i_cx, i_cy, i_cz} = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            send_triangle(dir_rows[r].tri_in, dir_rows[r].known, dir_rows[r].res);

        for (int n = 0; n < N_RANDOM; n++) begin
            // hold off once until the pipe has drained
            if (n == N_RANDOM / 2) begin
                start <= 1'b0;
                while (pending_normals.size() != 0)
                    @(posedge i_clk);
            end
            // long back-to-back stretch without gaps
            if (n >= 100 && n < 160) begin
                start <= 1'b1;
                {i_ax, i_ay, i_az, i_bx, i_by_coord, i_bz, i_cx, i_cy, i_cz}
                    <= random_triangle();
                @(posedge i_clk);
                if (!busy)
                    pending_normals.push_back(face_normal(
                        {i_ax, i_ay, i_az, i_bx, i_by_coord, i_bz, i_cx, i_cy, i_cz}));
                else
                    n--;
            end else begin
                send_triangle(random_triangle(), 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (pending_normals.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
